@@ src/integer_list_sorter_defines.svh @@
// Assertion helpers shared by the sorter RTL.
`ifndef INTEGER_LIST_SORTER_DEFINES_SVH
`define INTEGER_LIST_SORTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ils_pkg.sv @@
package ils_pkg;

	localparam int unsigned DataW = 32;

	typedef struct packed {
		logic signed [DataW-1:0] value;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic signed [DataW-1:0] sorted_value;
		logic                    end_of_list;
		logic                    dropped;
	} result_t;

	typedef enum logic [6:0] {
		S_LOAD    = 7'b0000001,
		S_PRIME   = 7'b0000010,
		S_FIRST   = 7'b0000100,
		S_PASS    = 7'b0001000,
		S_TAIL    = 7'b0010000,
		S_EMIT_RD = 7'b0100000,
		S_EMIT_WR = 7'b1000000
	} state_t;

endpackage

@@ src/integer_list_sorter.sv @@
// Integer list sorter.
// Input channel (in_valid/in_stall, in_item): one signed 32-bit value per
// transfer, the final value of a list flagged with last. Values are written
// to the element memory at one per cycle while in_stall is low. Values past
// MAX_ITEMS are dropped and every result of that list reports dropped.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): bit 0 selects a
// decreasing order; it is sampled when the last value of a list arrives.
// Once last is taken, in_stall stays high until the final result is loaded
// into the output stage; the next list may then load while it waits there.
// One compare unit walks the memory in bubble passes, one read and one write
// per cycle; each pass runs through S_PRIME, S_FIRST, S_PASS and S_TAIL, and
// passes repeat until one makes no swap. Results (out_valid/out_stall,
// out_item) then leave from a registered output stage, read in S_EMIT_RD and
// loaded in S_EMIT_WR, end_of_list on the final one; a stalled valid result
// holds, and the memory walk with it. A list of one value skips sorting.
// Reset (arst_n low) clears the count, the drop flag, the order bit and the
// output valid flag; the element memory is not cleared and needs no clearing pass.
`include "integer_list_sorter_defines.svh"

module integer_list_sorter
	import ils_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  item_t   in_item,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_data,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_item
);

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

	state_t state_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] ptr_q;
	logic          overflow_q;
	logic          drop_q;
	logic          desc_cfg_q;
	logic          desc_q;
	logic          swapped_q;

	logic signed [DataW-1:0] mem [MAX_ITEMS];
	logic signed [DataW-1:0] rd_data_q;
	logic signed [DataW-1:0] carry_q;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [DataW-1:0] mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;

	logic          out_valid_q;
	result_t       out_q;

	logic          in_accept;
	logic          store_full;
	logic [CW-1:0] last_idx;
	logic          ptr_at_last;
	logic          swap;
	logic          out_load;

	assign in_stall    = (state_q != S_LOAD);
	assign in_accept   = in_valid && !in_stall;
	assign cfg_ready   = 1'b1;
	assign store_full  = (count_q == MaxCount);
	assign last_idx    = n_q - 1'b1;
	assign ptr_at_last = (CW'(ptr_q) == last_idx);
	assign swap        = desc_q ? (carry_q < rd_data_q) : (carry_q > rd_data_q);
	assign out_load    = (state_q == S_EMIT_WR) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign out_item    = out_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = carry_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		unique case (state_q)
			S_LOAD: begin
				mem_we    = in_accept && !store_full;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = in_item.value;
			end
			S_PRIME: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
			end
			S_FIRST: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(1);
			end
			S_PASS: begin
				// keep the larger (in sort order) value moving up the array
				mem_we    = 1'b1;
				mem_waddr = ptr_q - 1'b1;
				mem_wdata = swap ? rd_data_q : carry_q;
				mem_re    = !ptr_at_last;
				mem_raddr = ptr_q + 1'b1;
			end
			S_TAIL: begin
				mem_we    = 1'b1;
				mem_waddr = last_idx[AW-1:0];
				mem_wdata = carry_q;
			end
			S_EMIT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q;
			end
			S_EMIT_WR: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_cfg_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			desc_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
			n_q        <= '0;
			ptr_q      <= '0;
			drop_q     <= 1'b0;
			desc_q     <= 1'b0;
			swapped_q  <= 1'b0;
			carry_q    <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_accept) begin
						if (in_item.last) begin
							n_q        <= store_full ? count_q : count_q + 1'b1;
							drop_q     <= overflow_q || store_full;
							desc_q     <= desc_cfg_q;
							count_q    <= '0;
							overflow_q <= 1'b0;
							ptr_q      <= '0;
							// a single value is already sorted
							state_q    <= (store_full || count_q != '0) ? S_PRIME : S_EMIT_RD;
						end else if (store_full) begin
							overflow_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_PRIME: begin
					swapped_q <= 1'b0;
					state_q   <= S_FIRST;
				end
				S_FIRST: begin
					carry_q <= rd_data_q;
					ptr_q   <= AW'(1);
					state_q <= S_PASS;
				end
				S_PASS: begin
					if (swap) begin
						swapped_q <= 1'b1;
					end else begin
						carry_q <= rd_data_q;
					end
					if (ptr_at_last) begin
						state_q <= S_TAIL;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_TAIL: begin
					ptr_q   <= '0;
					state_q <= swapped_q ? S_PRIME : S_EMIT_RD;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_load) begin
						if (ptr_at_last) begin
							state_q <= S_LOAD;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sorted_value <= rd_data_q;
			out_q.end_of_list  <= ptr_at_last;
			out_q.dropped      <= drop_q;
		end
	end

	`ILS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= MaxCount, "element count beyond capacity")
	`ILS_ASSERT_NEXT(a_last_blocks_input, in_accept && in_item.last, in_stall,
		"input not blocked after last element")
	`ILS_ASSERT_NOW(a_sort_needs_two, state_q == S_PASS || state_q == S_TAIL, n_q >= CW'(2),
		"sort pass on fewer than two elements")
	`ILS_ASSERT_NEXT(a_end_reopens, out_load && ptr_at_last,
		!in_stall && out_valid && out_item.end_of_list, "final result did not reopen input")

endmodule

@@ tb/integer_list_sorter_tb.sv @@
module integer_list_sorter_tb;
	import ils_pkg::*;

	localparam int unsigned LIST_CAP = 64;
	localparam int unsigned RANDOM_ITEMS = 320;
	localparam logic signed [DataW-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [DataW-1:0] MOST_POS = 32'sh7fff_ffff;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	item_t   in_item = '0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data = 1'b0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	result_t out_item;

	// stimulus and scoreboard state
	item_t       pending_items[$];
	result_t     sorted_results_due[$];
	logic signed [DataW-1:0] held_values[$];
	logic        list_overflow = 1'b0;
	logic        order_desc = 1'b0;
	bit          quiet_run = 1'b0;
	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned fail_count = 0;
	int unsigned in_gap = 0;
	int unsigned stall_left = 0;

	integer_list_sorter #(
		.MAX_ITEMS(LIST_CAP)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet_run)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DataW-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return MOST_NEG;
			1: return MOST_POS;
			2, 3: return $signed($urandom_range(0, 6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	// Store one accepted value; on the last one, queue the whole list in sorted order.
	task automatic absorb_value(input item_t it);
		logic signed [DataW-1:0] ordered[$];
		int unsigned pos;
		result_t r;
		if (held_values.size() < LIST_CAP)
			held_values.push_back(it.value);
		else
			list_overflow = 1'b1;
		if (it.last) begin
			foreach (held_values[i]) begin
				pos = 0;
				while (pos < ordered.size() && !(order_desc ? held_values[i] > ordered[pos]
						: held_values[i] < ordered[pos]))
					pos++;
				ordered.insert(pos, held_values[i]);
			end
			foreach (ordered[k]) begin
				r.sorted_value = ordered[k];
				r.end_of_list = (k == ordered.size() - 1);
				r.dropped = list_overflow;
				sorted_results_due.push_back(r);
			end
			held_values.delete();
			list_overflow = 1'b0;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (sorted_results_due.size() == 0) begin
			$error("unexpected result: sorted_value %0d end_of_list %0b dropped %0b",
				got.sorted_value, got.end_of_list, got.dropped);
			fail_count++;
			return;
		end
		want = sorted_results_due.pop_front();
		if (got.sorted_value !== want.sorted_value) begin
			$error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
			fail_count++;
		end
		if (got.end_of_list !== want.end_of_list) begin
			$error("end_of_list: expected %0b, got %0b", want.end_of_list, got.end_of_list);
			fail_count++;
		end
		if (got.dropped !== want.dropped) begin
			$error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
			fail_count++;
		end
	endtask

	// input driver: advance only after a transfer or while idle
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_items.size() != 0) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result(out_item);
			if (cfg_valid && cfg_ready)
				order_desc = cfg_data;
			if (in_valid && !in_stall) begin
				absorb_value(in_item);
				items_accepted++;
			end
		end
	end

	task automatic push_item(input logic signed [DataW-1:0] v, input logic is_last);
		item_t it;
		it.value = v;
		it.last = is_last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// hold until every item is taken and every result has left, then let the block settle
	task automatic wait_idle();
		while (pending_items.size() != 0 || items_accepted != items_queued
				|| sorted_results_due.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_order(input logic desc);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= desc;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned len;
		int unsigned kind;
		int unsigned list_no;
		int unsigned target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_order(1'b0);
		// single value skips the sort
		push_item(32'sd5, 1'b1);
		// extremes with duplicates, increasing
		push_item(MOST_NEG, 1'b0);
		push_item(MOST_POS, 1'b0);
		push_item(32'sd0, 1'b0);
		push_item(-32'sd1, 1'b0);
		push_item(32'sd1, 1'b0);
		push_item(MOST_POS, 1'b0);
		push_item(MOST_NEG, 1'b1);
		wait_idle();
		write_order(1'b1);
		push_item(-32'sd1, 1'b0);
		push_item(32'sd0, 1'b0);
		push_item(MOST_NEG, 1'b0);
		push_item(32'sd1, 1'b0);
		push_item(MOST_POS, 1'b0);
		push_item(32'sd0, 1'b1);
		// all equal, no swap ever needed
		push_item(32'sd3, 1'b0);
		push_item(32'sd3, 1'b0);
		push_item(32'sd3, 1'b1);

		target = items_queued + RANDOM_ITEMS;
		list_no = 0;
		while (items_queued < target) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				write_order($urandom_range(0, 1));
			end
			quiet_run = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 19);
			// first list overruns the store, second fills it exactly
			if (list_no == 0 || kind == 0)
				len = LIST_CAP + $urandom_range(1, 4);
			else if (list_no == 1 || kind == 1)
				len = LIST_CAP;
			else
				len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				push_item(pick_value(), i == len - 1);
			list_no++;
		end

		wait_idle();
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#10000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/ils_pkg.sv
src/integer_list_sorter.sv
tb/integer_list_sorter_tb.sv
